// ===== design/kpc_pkg.sv =====
package kpc_pkg;

    localparam int SAMPLE_W         = 12;
    localparam int PEAK_W           = 12;
    localparam int CHAR_W           = 8;
    localparam int WLEN_W           = 8;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 8'd50;

    localparam logic OP_KEY    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic KEY_PRESSED  = 1'b0;
    localparam logic KEY_RELEASED = 1'b1;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] LINE_FEED  = 8'd10;

    localparam int CHAR_COUNT = 5;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] IDX_THOUSANDS = 3'd0;
    localparam logic [IDX_W-1:0] IDX_HUNDREDS  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_TENS      = 3'd2;
    localparam logic [IDX_W-1:0] IDX_UNITS     = 3'd3;
    localparam logic [IDX_W-1:0] IDX_NEWLINE   = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [PEAK_W-1:0] peak;
    } peak_xfer_t;

    typedef struct packed {
        logic [3:0]        digit;
        logic [PEAK_W-1:0] sub;
    } digit_t;

    // decimal digit of rem at a constant place, and the amount to take off
    function automatic digit_t digit_at(input logic [PEAK_W-1:0] rem,
                                        input int unsigned place);
        digit_t d;
        d.digit = 4'd0;
        d.sub   = '0;
        for (int unsigned k = 1; k <= 9; k++) begin
            if (14'(rem) >= 14'(k * place)) begin
                d.digit = 4'(k);
                d.sub   = PEAK_W'(k * place);
            end
        end
        return d;
    endfunction

endpackage

// ===== design/kpc_front.sv =====
module kpc_front #(
    parameter int SAMPLE_BITS = kpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [kpc_pkg::WLEN_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic                         s_key_level,
    input  logic [kpc_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                         q_full,
    output kpc_pkg::peak_xfer_t          push
);

    localparam int KEEP_BITS = (SAMPLE_BITS < kpc_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                 : kpc_pkg::SAMPLE_W;

    logic [kpc_pkg::WLEN_W-1:0] wlen_reg;
    logic                       armed_reg, armed_next;
    logic                       capt_reg, capt_next;
    logic [kpc_pkg::WLEN_W-1:0] seen_reg, seen_next;
    logic [KEEP_BITS-1:0]       max_reg, max_next;

    logic                       xfer;
    logic [KEEP_BITS-1:0]       smp;
    logic [KEEP_BITS-1:0]       new_max;
    logic [kpc_pkg::WLEN_W-1:0] seen_inc;

    assign s_ready  = !q_full;
    assign xfer     = s_valid && s_ready;
    assign smp      = s_sample[KEEP_BITS-1:0];
    assign new_max  = (smp > max_reg) ? smp : max_reg;
    assign seen_inc = seen_reg + kpc_pkg::WLEN_W'(1);

    always_comb begin
        armed_next = armed_reg;
        capt_next  = capt_reg;
        seen_next  = seen_reg;
        max_next   = max_reg;
        push.valid = 1'b0;
        push.peak  = kpc_pkg::PEAK_W'(new_max);
        if (xfer) begin
            if (s_op == kpc_pkg::OP_KEY) begin
                if (s_key_level == kpc_pkg::KEY_PRESSED && armed_reg) begin
                    armed_next = 1'b0;
                    if (!capt_reg) begin
                        capt_next = 1'b1;
                        seen_next = '0;
                        max_next  = '0;
                    end
                end else if (s_key_level == kpc_pkg::KEY_RELEASED && !armed_reg) begin
                    armed_next = 1'b1;
                end
            end else if (capt_reg) begin
                max_next  = new_max;
                seen_next = seen_inc;
                if (seen_inc == wlen_reg) begin
                    capt_next  = 1'b0;
                    push.valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg  <= kpc_pkg::WLEN_RESET;
            armed_reg <= 1'b1;
            capt_reg  <= 1'b0;
            seen_reg  <= '0;
            max_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
            armed_reg <= armed_next;
            capt_reg  <= capt_next;
            seen_reg  <= seen_next;
            max_reg   <= max_next;
        end
    end

endmodule

// ===== design/kpc_queue.sv =====
module kpc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  kpc_pkg::peak_xfer_t push,
    output logic                full,
    output kpc_pkg::peak_xfer_t head,
    input  logic                pop
);

    localparam int DEPTH = kpc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [kpc_pkg::PEAK_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.peak  = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.peak;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/kpc_back.sv =====
module kpc_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  kpc_pkg::peak_xfer_t        head,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [kpc_pkg::CHAR_W-1:0] m_out_char,
    output logic [kpc_pkg::PEAK_W-1:0] m_peak_value,
    output logic                       m_last_char
);

    logic                        active_reg, active_next;
    logic [kpc_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [kpc_pkg::PEAK_W-1:0]  rem_reg, rem_next;
    logic [kpc_pkg::PEAK_W-1:0]  peak_reg, peak_next;

    logic                        m_valid_reg, m_valid_next;
    logic [kpc_pkg::CHAR_W-1:0]  m_char_reg;
    logic [kpc_pkg::PEAK_W-1:0]  m_peak_reg;
    logic                        m_last_reg;

    logic                        adv;
    logic                        is_last;
    kpc_pkg::digit_t             dig;
    logic [kpc_pkg::CHAR_W-1:0]  cur_char;

    assign is_last = (idx_reg == kpc_pkg::IDX_NEWLINE);
    assign adv     = active_reg && (!m_valid_reg || m_ready);
    assign pop     = head.valid && (!active_reg || (adv && is_last));

    always_comb begin
        case (idx_reg)
            kpc_pkg::IDX_THOUSANDS: dig = kpc_pkg::digit_at(rem_reg, 1000);
            kpc_pkg::IDX_HUNDREDS:  dig = kpc_pkg::digit_at(rem_reg, 100);
            kpc_pkg::IDX_TENS:      dig = kpc_pkg::digit_at(rem_reg, 10);
            kpc_pkg::IDX_UNITS:     dig = kpc_pkg::digit_at(rem_reg, 1);
            default:                dig = '0;
        endcase
        cur_char = is_last ? kpc_pkg::LINE_FEED
                           : kpc_pkg::ASCII_ZERO + kpc_pkg::CHAR_W'(dig.digit);
    end

    always_comb begin
        active_next  = active_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        peak_next    = peak_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (adv) begin
            m_valid_next = 1'b1;
            idx_next     = idx_reg + kpc_pkg::IDX_W'(1);
            rem_next     = rem_reg - dig.sub;
            if (is_last) begin
                active_next = 1'b0;
            end
        end
        if (pop) begin
            active_next = 1'b1;
            idx_next    = kpc_pkg::IDX_THOUSANDS;
            rem_next    = head.peak;
            peak_next   = head.peak;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_char_reg <= cur_char;
            m_peak_reg <= peak_reg;
            m_last_reg <= is_last;
        end
        rem_reg  <= rem_next;
        peak_reg <= peak_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            idx_reg     <= kpc_pkg::IDX_THOUSANDS;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_char   = m_char_reg;
    assign m_peak_value = m_peak_reg;
    assign m_last_char  = m_last_reg;

endmodule

// ===== design/key_triggered_peak_capture_unit.sv =====
// Input: one transfer per cycle; s_ready drops only while the peak queue is full.
// After the window's last sample is taken, the peak passes the queue and the back
// end's output register; the report is 5 bytes, one per cycle while m_ready is high.
// A queued peak loads as the line feed is registered; the serialiser sets the rate.
// Reset (aresetn, synchronous, active low): key armed, no window, length 50, queue empty.
module key_triggered_peak_capture_unit #(
    parameter int SAMPLE_BITS = kpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [kpc_pkg::WLEN_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic                         s_key_level,
    input  logic [kpc_pkg::SAMPLE_W-1:0] s_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [kpc_pkg::CHAR_W-1:0]   m_out_char,
    output logic [kpc_pkg::PEAK_W-1:0]   m_peak_value,
    output logic                         m_last_char
);

    kpc_pkg::peak_xfer_t push;
    kpc_pkg::peak_xfer_t head;
    logic                q_full;
    logic                pop;

    kpc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_key_level (s_key_level),
        .s_sample    (s_sample),
        .q_full      (q_full),
        .push        (push)
    );

    kpc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .head    (head),
        .pop     (pop)
    );

    kpc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_peak_value (m_peak_value),
        .m_last_char  (m_last_char)
    );

endmodule
